@@ hdl/fst_pkg.sv @@
package fst_pkg;

  // Accumulator width and headroom for the increment before saturation
  localparam int unsigned VOLUME_BITS     = 48;
  localparam int unsigned INC_W           = 52;
  localparam int unsigned MAX_SOFT_RESETS = 2;

  // Shared multiplier operand widths (signed)
  localparam int unsigned MUL_A_W = 19;
  localparam int unsigned MUL_B_W = 33;

  // Q2.16 slope: fraction bits and rounding constant
  localparam int unsigned SLOPE_FRAC = 16;

  localparam logic signed [INC_W-1:0] VOL_MAX =
    {{(INC_W-VOLUME_BITS+1){1'b0}}, {(VOLUME_BITS-1){1'b1}}};
  localparam logic signed [INC_W-1:0] VOL_MIN =
    {{(INC_W-VOLUME_BITS+1){1'b1}}, {(VOLUME_BITS-1){1'b0}}};
  localparam logic signed [INC_W-1:0] ROUND_HALF =
    {{(INC_W-SLOPE_FRAC){1'b0}}, 1'b1, {(SLOPE_FRAC-1){1'b0}}};

  localparam logic [17:0] SLOPE_RESET = 18'h10000;

  typedef enum logic [2:0] {
    MODE_FRAME     = 3'd0,
    MODE_SHORT     = 3'd1,
    MODE_START     = 3'd2,
    MODE_STOP      = 3'd3,
    MODE_RST_DISP  = 3'd4,
    MODE_RST_TOTAL = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    REG_CORR_EN = 2'd0,
    REG_SLOPE   = 2'd1,
    REG_OFFSET  = 2'd2
  } reg_idx_e;

  function automatic logic signed [VOLUME_BITS-1:0] sat_add(
    input logic signed [VOLUME_BITS-1:0] acc,
    input logic signed [INC_W-1:0]       inc
  );
    logic signed [INC_W-1:0] sum;
    sum = INC_W'(acc) + inc;
    if (sum > VOL_MAX) begin
      sum = VOL_MAX;
    end else if (sum < VOL_MIN) begin
      sum = VOL_MIN;
    end
    return sum[VOLUME_BITS-1:0];
  endfunction

endpackage

@@ hdl/flow_sensor_totalizer_core.sv @@
// Flow sensor volume totalizer.
// Input channel (in_valid_i/in_ready_o) carries one event per transaction:
// sensor frame, short frame, start, stop, reset dispensed, reset total.
// Output channel (out_valid_o/out_ready_i) returns one result per event,
// with volumes and flags showing the state after the event.
// Config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 is
// correction enable, 1 the Q2.16 slope, 2 the signed offset; other indexes
// are dropped. Write it only while the block is idle.
// Events with no volume math go from accept straight to ST_FINISH; a
// frame that integrates volume first passes ST_MUL_P, and with correction
// enabled also ST_MUL_LO, ST_MUL_HI and ST_MUL_OFS. These steps share one
// 19x33 multiplier that computes flow*dt, slope*low, slope*high and
// offset*dt in turn. The block takes one event at a time; in_ready_o
// returns as the result is registered, alongside out_valid_o.
// A stalled receiver holds the result in the output register; the next
// event is still accepted and computed, and waits in its final step until
// the output register frees up.
// Reset (rst_ni low, async) sets stopped, clears other flags, timestamp,
// both accumulators and retry count; config to slope 1.0, no correction.
module flow_sensor_totalizer_core
  import fst_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [17:0]                   cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    mode_i,
  input  logic signed [15:0]            flow_raw_i,
  input  logic signed [15:0]            temp_raw_i,
  input  logic [15:0]                   aux_raw_i,
  input  logic [31:0]                   time_ms_i,
  input  logic                          link_ok_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          success_o,
  output logic                          reading_valid_o,
  output logic [14:0]                   flow_rate_o,
  output logic signed [15:0]            temperature_o,
  output logic                          high_flow_o,
  output logic signed [VOLUME_BITS-1:0] dispensed_volume_o,
  output logic signed [VOLUME_BITS-1:0] total_volume_o,
  output logic                          connected_o,
  output logic                          running_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MUL_P   = 6'b000010,
    ST_MUL_LO  = 6'b000100,
    ST_MUL_HI  = 6'b001000,
    ST_MUL_OFS = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic               corr_en_q;
  logic [17:0]        slope_q;
  logic signed [15:0] offset_q;

  // persistent block state
  logic                          init_q, init_d;
  logic                          stopped_q, stopped_d;
  logic                          conn_q, conn_d;
  logic [31:0]                   last_time_q, last_time_d;
  logic signed [VOLUME_BITS-1:0] disp_q, disp_d;
  logic signed [VOLUME_BITS-1:0] total_q, total_d;
  logic [1:0]                    retry_q, retry_d;

  // captured event
  mode_e              mode_q;
  logic [14:0]        flow_q;
  logic signed [15:0] temp_q;
  logic               hf_q;
  logic [31:0]        time_q;
  logic               link_q;
  logic [31:0]        dt_q;

  // arithmetic
  logic [46:0]             p_q, p_d;
  logic signed [INC_W-1:0] inc_q, inc_d;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [INC_W-1:0]   prod;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          succ_q, succ_d;
  logic                          rv_q, rv_d;
  logic [14:0]                   flow_o_q, flow_o_d;
  logic signed [15:0]            temp_o_q, temp_o_d;
  logic                          hf_o_q, hf_o_d;
  logic signed [VOLUME_BITS-1:0] disp_o_q;
  logic signed [VOLUME_BITS-1:0] total_o_q;
  logic                          conn_o_q;
  logic                          run_o_q;
  logic                          load_out;

  logic                          accept;
  logic                          running;
  logic                          do_mul;
  logic [14:0]                   flow_clamp;
  logic signed [VOLUME_BITS-1:0] disp_sum;
  logic signed [VOLUME_BITS-1:0] total_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign running     = init_q && !stopped_q;
  assign do_mul      = (mode_i == MODE_FRAME) && running && (last_time_q != 32'd0);
  assign flow_clamp  = flow_raw_i[15] ? 15'd0 : flow_raw_i[14:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_P: begin
        mul_a = {4'b0, flow_q};
        mul_b = {1'b0, dt_q};
      end
      ST_MUL_LO: begin
        mul_a = {1'b0, slope_q};
        mul_b = {17'b0, p_q[15:0]};
      end
      ST_MUL_HI: begin
        mul_a = {1'b0, slope_q};
        mul_b = {2'b0, p_q[46:16]};
      end
      ST_MUL_OFS: begin
        mul_a = {{3{offset_q[15]}}, offset_q};
        mul_b = {1'b0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = INC_W'(mul_a) * INC_W'(mul_b);
  assign disp_sum  = sat_add(disp_q, inc_q);
  assign total_sum = sat_add(total_q, inc_q);

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    inc_d       = inc_q;
    init_d      = init_q;
    stopped_d   = stopped_q;
    conn_d      = conn_q;
    last_time_d = last_time_q;
    disp_d      = disp_q;
    total_d     = total_q;
    retry_d     = retry_q;
    succ_d      = 1'b0;
    rv_d        = 1'b0;
    flow_o_d    = '0;
    temp_o_d    = '0;
    hf_o_d      = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          inc_d   = '0;
          state_d = do_mul ? ST_MUL_P : ST_FINISH;
        end
      end
      ST_MUL_P: begin
        p_d     = prod[46:0];
        inc_d   = prod;
        state_d = corr_en_q ? ST_MUL_LO : ST_FINISH;
      end
      ST_MUL_LO: begin
        inc_d   = (prod + ROUND_HALF) >>> SLOPE_FRAC;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        inc_d   = inc_q + prod;
        state_d = ST_MUL_OFS;
      end
      ST_MUL_OFS: begin
        inc_d   = inc_q + prod;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          case (mode_q)
            MODE_FRAME, MODE_SHORT: begin
              if (!running) begin
                if (total_q == '0) begin
                  disp_d = '0;
                end
              end else if (mode_q == MODE_SHORT) begin
                if ((retry_q < 2'(MAX_SOFT_RESETS)) && link_q) begin
                  retry_d = retry_q + 2'd1;
                end else begin
                  init_d    = 1'b0;
                  stopped_d = 1'b1;
                  conn_d    = 1'b0;
                  retry_d   = '0;
                end
              end else begin
                retry_d     = '0;
                conn_d      = 1'b1;
                disp_d      = disp_sum;
                total_d     = total_sum;
                last_time_d = time_q;
                succ_d      = 1'b1;
                rv_d        = 1'b1;
                flow_o_d    = flow_q;
                temp_o_d    = temp_q;
                hf_o_d      = hf_q;
              end
            end
            MODE_START: begin
              if (link_q) begin
                conn_d      = 1'b1;
                init_d      = 1'b1;
                stopped_d   = 1'b0;
                disp_d      = '0;
                last_time_d = time_q;
                succ_d      = 1'b1;
              end else begin
                conn_d = 1'b0;
              end
            end
            MODE_STOP: begin
              init_d    = 1'b0;
              stopped_d = 1'b1;
              succ_d    = link_q;
            end
            MODE_RST_DISP: begin
              disp_d      = '0;
              last_time_d = time_q;
              stopped_d   = 1'b1;
              succ_d      = 1'b1;
            end
            MODE_RST_TOTAL: begin
              total_d = '0;
              succ_d  = 1'b1;
            end
            default: begin
              succ_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      corr_en_q   <= 1'b0;
      slope_q     <= SLOPE_RESET;
      offset_q    <= '0;
      init_q      <= 1'b0;
      stopped_q   <= 1'b1;
      conn_q      <= 1'b0;
      last_time_q <= '0;
      disp_q      <= '0;
      total_q     <= '0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      stopped_q   <= stopped_d;
      conn_q      <= conn_d;
      last_time_q <= last_time_d;
      disp_q      <= disp_d;
      total_q     <= total_d;
      retry_q     <= retry_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_CORR_EN: corr_en_q <= cfg_data_i[0];
          REG_SLOPE:   slope_q   <= cfg_data_i;
          REG_OFFSET:  offset_q  <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath and payload registers
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    inc_q <= inc_d;
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      flow_q <= flow_clamp;
      temp_q <= temp_raw_i;
      hf_q   <= aux_raw_i[1];
      time_q <= time_ms_i;
      link_q <= link_ok_i;
      dt_q   <= time_ms_i - last_time_q;
    end
    if (load_out) begin
      succ_q    <= succ_d;
      rv_q      <= rv_d;
      flow_o_q  <= flow_o_d;
      temp_o_q  <= temp_o_d;
      hf_o_q    <= hf_o_d;
      disp_o_q  <= disp_d;
      total_o_q <= total_d;
      conn_o_q  <= conn_d;
      run_o_q   <= init_d && !stopped_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign success_o          = succ_q;
  assign reading_valid_o    = rv_q;
  assign flow_rate_o        = flow_o_q;
  assign temperature_o      = temp_o_q;
  assign high_flow_o        = hf_o_q;
  assign dispensed_volume_o = disp_o_q;
  assign total_volume_o     = total_o_q;
  assign connected_o        = conn_o_q;
  assign running_o          = run_o_q;

endmodule

@@ hdl/fst_checker.sv @@
module fst_checker
  import fst_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          success_o,
  input logic                          reading_valid_o,
  input logic [14:0]                   flow_rate_o,
  input logic signed [15:0]            temperature_o,
  input logic                          high_flow_o,
  input logic signed [VOLUME_BITS-1:0] dispensed_volume_o,
  input logic signed [VOLUME_BITS-1:0] total_volume_o,
  input logic                          connected_o,
  input logic                          running_o
);

  // one event in flight: an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while previous event still in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(dispensed_volume_o) && $stable(total_volume_o)))
    else $error("stalled result changed");

  a_no_reading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reading_valid_o) |->
      (flow_rate_o == 15'd0 && temperature_o == 16'sd0 && !high_flow_o))
    else $error("reading fields nonzero without a fresh reading");

  a_reading_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reading_valid_o) |-> (success_o && connected_o && running_o))
    else $error("fresh reading reported while not running and connected");

endmodule

bind flow_sensor_totalizer_core fst_checker u_fst_checker (.*);
